@@ src/pcf_pkg.sv @@
package pcf_pkg;

    // Frame size limits
    localparam int MAX_FRAME_BYTES = 512;
    localparam int COUNT_CAP       = 1023;
    localparam int KEEP_LIMIT      = (MAX_FRAME_BYTES < COUNT_CAP) ? MAX_FRAME_BYTES : COUNT_CAP;

    localparam int LEN_W  = 10;
    localparam int WORD_W = 32;

    // Request codes
    localparam logic REQ_BEGIN = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_LINK_CODE   = 1'b0;
    localparam logic CFG_SNAP_LENGTH = 1'b1;

    localparam logic [15:0] LINK_CODE_RESET   = 16'd105;
    localparam logic [15:0] SNAP_LENGTH_RESET = 16'hFFFF;

    // Output slots of one command
    localparam int SLOT_N = 12;
    localparam int SLOT_W = 4;

    // Frame command slots: packet block header, packed word, flush, trailer
    localparam logic [SLOT_W-1:0] SLOT_EPB_TYPE  = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_EPB_LEN   = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_EPB_IF    = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_EPB_TSH   = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_EPB_TSL   = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_EPB_CAP   = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_EPB_ORIG  = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_DATA      = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_FLUSH     = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_TRAILER   = 4'd9;

    // Section command slots that are block ends or not fixed words
    localparam logic [SLOT_W-1:0] SLOT_SHB_END   = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_LINK      = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_SNAP      = 4'd10;
    localparam logic [SLOT_W-1:0] SLOT_IDB_END   = 4'd11;

    localparam logic [SLOT_N-1:0] BEGIN_MASK = 12'hFFF;
    localparam logic [SLOT_N-1:0] HDR_MASK   = 12'h07F;

    localparam logic [WORD_W-1:0] EPB_TYPE_WORD = 32'd6;

    // Section header and interface description words; link and snap slots filled later
    localparam logic [WORD_W-1:0] BEGIN_WORDS [SLOT_N] = '{
        32'h0A0D0D0A, 32'd28, 32'h1A2B3C4D, 32'h00000001,
        32'hFFFFFFFF, 32'hFFFFFFFF, 32'd28, 32'd1,
        32'd20, 32'd0, 32'd0, 32'd20
    };

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SLOT_N-1:0] mask;
        logic              is_begin;
        logic [31:0]       ts;
        logic [LEN_W-1:0]  hdr_len;
        logic [LEN_W-1:0]  trl_len;
        logic              mismatch;
        logic [31:0]       data_word;
        logic [23:0]       flush_word;
    } pcf_cmd_t;

    function automatic logic [WORD_W-1:0] block_len_of(input logic [LEN_W-1:0] len);
        logic [LEN_W:0]   padded;
        logic [LEN_W+1:0] total;
        padded = ({1'b0, len} + (LEN_W+1)'(3)) & ~(LEN_W+1)'(3);
        total  = {1'b0, padded} + (LEN_W+2)'(32);
        return WORD_W'(total);
    endfunction

endpackage

@@ src/pcf_front.sv @@
module pcf_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    req_type,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    input  logic [9:0]              pkt_len,
    input  logic [31:0]             timestamp_usec,
    input  logic                    q_full,
    output logic                    push,
    output pcf_pkg::pcf_cmd_t       cmd
);
    import pcf_pkg::*;

    logic [23:0]      gather_reg, gather_next;
    logic [1:0]       fill_reg, fill_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             in_frame_reg, in_frame_next;
    logic [LEN_W-1:0] len;
    logic             accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign len      = (32'(pkt_len) > MAX_FRAME_BYTES) ? LEN_W'(MAX_FRAME_BYTES) : pkt_len;

    always_comb
    begin
        cmd           = '0;
        gather_next   = gather_reg;
        fill_next     = fill_reg;
        count_next    = count_reg;
        in_frame_next = in_frame_reg;
        if (req_type == REQ_BEGIN)
        begin
            cmd.mask      = BEGIN_MASK;
            cmd.is_begin  = 1'b1;
            gather_next   = '0;
            fill_next     = '0;
            count_next    = '0;
            in_frame_next = 1'b0;
        end
        else
        begin
            if (!in_frame_reg)
            begin
                cmd.mask    = HDR_MASK;
                cmd.hdr_len = len;
                cmd.ts      = timestamp_usec;
            end
            // bytes past the limit are dropped
            if (count_reg < LEN_W'(KEEP_LIMIT))
            begin
                count_next = count_reg + LEN_W'(1);
                if (fill_reg == 2'd3)
                begin
                    cmd.mask[SLOT_DATA] = 1'b1;
                    cmd.data_word       = {data_byte, gather_reg};
                    gather_next         = '0;
                    fill_next           = '0;
                end
                else
                begin
                    case (fill_reg)
                        2'd0:    gather_next[7:0]   = data_byte;
                        2'd1:    gather_next[15:8]  = data_byte;
                        default: gather_next[23:16] = data_byte;
                    endcase
                    fill_next = fill_reg + 2'd1;
                end
            end
            if (last_byte)
            begin
                cmd.mask[SLOT_FLUSH]   = (fill_next != 2'd0);
                cmd.flush_word         = gather_next;
                cmd.mask[SLOT_TRAILER] = 1'b1;
                cmd.trl_len            = len;
                cmd.mismatch           = (count_next != len);
                gather_next            = '0;
                fill_next              = '0;
                count_next             = '0;
                in_frame_next          = 1'b0;
            end
            else
            begin
                in_frame_next = 1'b1;
            end
        end
    end

    assign push = accept && (cmd.mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gather_reg   <= '0;
            fill_reg     <= '0;
            count_reg    <= '0;
            in_frame_reg <= 1'b0;
        end
        else if (accept)
        begin
            gather_reg   <= gather_next;
            fill_reg     <= fill_next;
            count_reg    <= count_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

@@ src/pcf_queue.sv @@
module pcf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pcf_pkg::pcf_cmd_t   push_cmd,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output pcf_pkg::pcf_cmd_t   head
);
    import pcf_pkg::*;

    pcf_cmd_t            entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

@@ src/pcf_back.sv @@
module pcf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  pcf_pkg::pcf_cmd_t   q_head,
    output logic                pop,
    input  logic [15:0]         link_code,
    input  logic [15:0]         snap_length,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         word,
    output logic                last_of_run,
    output logic                block_end,
    output logic                length_mismatch
);
    import pcf_pkg::*;

    pcf_cmd_t           cur_reg, cur_next;
    logic [SLOT_N-1:0]  mask_reg, mask_next, mask_after, low_bit;
    logic [SLOT_W-1:0]  slot;
    logic               advance, emit;
    logic               valid_reg, last_reg, end_reg, mis_reg;
    logic [31:0]        word_reg, slot_word;
    logic               slot_end, slot_mis;

    assign advance    = !valid_reg || out_ready;
    assign emit       = advance && (mask_reg != '0);
    assign low_bit    = mask_reg & (~mask_reg + SLOT_N'(1));
    assign mask_after = emit ? (mask_reg & ~low_bit) : mask_reg;
    assign pop        = (mask_after == '0) && q_not_empty;
    assign mask_next  = pop ? q_head.mask : mask_after;
    assign cur_next   = pop ? q_head : cur_reg;

    always_comb
    begin
        slot = '0;
        for (int i = SLOT_N - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                slot = SLOT_W'(i);
        end
    end

    // Word for the current slot
    always_comb
    begin
        slot_word = '0;
        slot_end  = 1'b0;
        slot_mis  = 1'b0;
        if (cur_reg.is_begin)
        begin
            slot_word = BEGIN_WORDS[slot];
            if (slot == SLOT_LINK)
                slot_word = {16'd0, link_code};
            else if (slot == SLOT_SNAP)
                slot_word = {16'd0, snap_length};
            slot_end = (slot == SLOT_SHB_END) || (slot == SLOT_IDB_END);
        end
        else
        begin
            unique case (slot) inside
                SLOT_EPB_TYPE:  slot_word = EPB_TYPE_WORD;
                SLOT_EPB_LEN:   slot_word = block_len_of(cur_reg.hdr_len);
                SLOT_EPB_TSL:   slot_word = cur_reg.ts;
                SLOT_EPB_CAP,
                SLOT_EPB_ORIG:  slot_word = 32'(cur_reg.hdr_len);
                SLOT_DATA:      slot_word = cur_reg.data_word;
                SLOT_FLUSH:     slot_word = {8'd0, cur_reg.flush_word};
                SLOT_TRAILER:
                begin
                    slot_word = block_len_of(cur_reg.trl_len);
                    slot_end  = 1'b1;
                    slot_mis  = cur_reg.mismatch;
                end
                default:        slot_word = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            word_reg <= slot_word;
            last_reg <= (mask_after == '0);
            end_reg  <= slot_end;
            mis_reg  <= slot_mis;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (emit)
                valid_reg <= 1'b1;
            else if (advance)
                valid_reg <= 1'b0;
        end
    end

    assign out_valid       = valid_reg;
    assign word            = word_reg;
    assign last_of_run     = last_reg;
    assign block_end       = end_reg;
    assign length_mismatch = mis_reg;

endmodule

@@ src/pcapng_capture_framer.sv @@
// pcapng capture framer: turns begin items and frame-byte items into a pcapng word stream,
// one little-endian 32-bit word per output item. A begin item yields the section header
// and interface description blocks (12 words); the first byte of a frame yields the
// 7-word packet block header; every fourth kept byte yields a packed word; the last byte
// yields the zero-padded partial word, if any, and the trailer word, whose length_mismatch
// flag is set when the kept byte count differs from the declared length capped at 512.
// An input item is taken whenever the 4-entry command queue has room, so frame bytes
// stream in at one per cycle while it does. The output side delivers one word per cycle
// from the back-end sequencer while out_ready is held; a begin item thus fills 12 output
// words and a frame start 7, or 9 when it is also the last byte, and the input stalls
// only once the queue fills behind it. Configuration registers are to be written only
// while the block is idle.
module pcapng_capture_framer (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [9:0]  pkt_len,
    input  logic [31:0] timestamp_usec,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] word,
    output logic        last_of_run,
    output logic        block_end,
    output logic        length_mismatch
);
    import pcf_pkg::*;

    logic [15:0] link_code_reg;
    logic [15:0] snap_length_reg;

    pcf_cmd_t    push_cmd;
    pcf_cmd_t    head_cmd;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_not_empty;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_code_reg   <= LINK_CODE_RESET;
            snap_length_reg <= SNAP_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LINK_CODE:   link_code_reg   <= cfg_data;
                CFG_SNAP_LENGTH: snap_length_reg <= cfg_data;
                default:         link_code_reg   <= link_code_reg;
            endcase
        end
    end

    // Front: take each item, track word packing and frame state, build at most one command
    pcf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .pkt_len        (pkt_len),
        .timestamp_usec (timestamp_usec),
        .q_full         (q_full),
        .push           (push),
        .cmd            (push_cmd)
    );

    // Hold commands between the two sides so each can stall on its own
    pcf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    // Back: each command's words leave via an output register, one per cycle on out_ready
    pcf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_head          (head_cmd),
        .pop             (pop),
        .link_code       (link_code_reg),
        .snap_length     (snap_length_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .word            (word),
        .last_of_run     (last_of_run),
        .block_end       (block_end),
        .length_mismatch (length_mismatch)
    );

endmodule
